/* rtl/core/ata_pkg.sv */
package ata_pkg;

    localparam int TABLE_LEN = 24;
    localparam int ANG_FRAC = 16;
    localparam int TILT_W = 15;
    localparam int ACC_W = 32;
    localparam logic [ACC_W-1:0] QUARTER_TURN = 32'd589824000;

    typedef logic [ACC_W-1:0] atan_word_t;

    function automatic atan_word_t atan_entry(input logic [4:0] idx);
        atan_word_t r;
        r = '0;
        case (idx)
            5'd0:  r = 32'd294912000;
            5'd1:  r = 32'd174096719;
            5'd2:  r = 32'd91987925;
            5'd3:  r = 32'd46694507;
            5'd4:  r = 32'd23437865;
            5'd5:  r = 32'd11730358;
            5'd6:  r = 32'd5866610;
            5'd7:  r = 32'd2933484;
            5'd8:  r = 32'd1466764;
            5'd9:  r = 32'd733385;
            5'd10: r = 32'd366693;
            5'd11: r = 32'd183346;
            5'd12: r = 32'd91673;
            5'd13: r = 32'd45837;
            5'd14: r = 32'd22918;
            5'd15: r = 32'd11459;
            5'd16: r = 32'd5730;
            5'd17: r = 32'd2865;
            5'd18: r = 32'd1432;
            5'd19: r = 32'd716;
            5'd20: r = 32'd358;
            5'd21: r = 32'd179;
            5'd22: r = 32'd90;
            5'd23: r = 32'd45;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/accel_tilt_angles_top.sv */
// Tilt angles from one three-axis accelerometer sample. A fully pipelined datapath:
// registered squaring, then registered sums; a bit-per-stage square root with
// SAMPLE_BITS+9 result bits; three parallel CORDIC lanes of CORDIC_STEPS (max 24)
// iterations; then one output register. One request is accepted every clock while
// the pipeline advances, which it does whenever its output register is empty or
// being taken.
module accel_tilt_angles_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // accel_x, accel_y, accel_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata // tilt_x, tilt_y, tilt_z, degenerate_mask
);
    import ata_pkg::*;

    localparam int SW = SAMPLE_BITS;
    localparam int MAG_W = SW + 9;
    localparam int SQ_W = 2 * SW + 1;
    localparam int RAD_W = 2 * MAG_W;
    localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int LAT = 2 + MAG_W + STEPS;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic m_valid_reg;
    logic [47:0] m_data_reg;

    assign en = !m_valid_reg || m_tready;
    assign s_tready = en && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            m_valid_reg <= vld_reg[LAT-1];
        end
    end

    logic signed [SW-1:0] x, y, z;
    assign x = $signed(s_tdata[SW-1:0]);
    assign y = $signed(s_tdata[2*SW-1:SW]);
    assign z = $signed(s_tdata[3*SW-1:2*SW]);

    logic [SW:0] ax_reg, ay_reg, az_reg;
    logic sx_reg, sy_reg, sz_reg;
    logic [SQ_W-2:0] xx_reg, yy_reg, zz_reg;
    logic [RAD_W-1:0] ryz_reg, rxz_reg, rxy_reg;
    logic [SW:0] ax2_reg, ay2_reg, az2_reg;
    logic sx2_reg, sy2_reg, sz2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg <= x[SW-1] ? (SW+1)'(-(SW+1)'(x)) : (SW+1)'(x);
            ay_reg <= y[SW-1] ? (SW+1)'(-(SW+1)'(y)) : (SW+1)'(y);
            az_reg <= z[SW-1] ? (SW+1)'(-(SW+1)'(z)) : (SW+1)'(z);
            sx_reg <= x[SW-1];
            sy_reg <= y[SW-1];
            sz_reg <= z[SW-1];
            xx_reg <= (SQ_W-1)'(x * x);
            yy_reg <= (SQ_W-1)'(y * y);
            zz_reg <= (SQ_W-1)'(z * z);
            ryz_reg <= RAD_W'({(SQ_W)'(yy_reg) + (SQ_W)'(zz_reg), 16'd0});
            rxz_reg <= RAD_W'({(SQ_W)'(xx_reg) + (SQ_W)'(zz_reg), 16'd0});
            rxy_reg <= RAD_W'({(SQ_W)'(xx_reg) + (SQ_W)'(yy_reg), 16'd0});
            ax2_reg <= ax_reg;
            ay2_reg <= ay_reg;
            az2_reg <= az_reg;
            sx2_reg <= sx_reg;
            sy2_reg <= sy_reg;
            sz2_reg <= sz_reg;
        end
    end

    logic [MAG_W-1:0] hyz, hxz, hxy;
    ata_isqrt #(.IN_W(RAD_W), .OUT_W(MAG_W)) u_sq_yz (
        .aclk(aclk), .en(en), .rad(ryz_reg), .root(hyz));
    ata_isqrt #(.IN_W(RAD_W), .OUT_W(MAG_W)) u_sq_xz (
        .aclk(aclk), .en(en), .rad(rxz_reg), .root(hxz));
    ata_isqrt #(.IN_W(RAD_W), .OUT_W(MAG_W)) u_sq_xy (
        .aclk(aclk), .en(en), .rad(rxy_reg), .root(hxy));

    logic [3*(SW+1)+2:0] dly_reg [MAG_W];
    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= {sz2_reg, sy2_reg, sx2_reg, az2_reg, ay2_reg, ax2_reg};
            for (int i = 1; i < MAG_W; i++) dly_reg[i] <= dly_reg[i-1];
        end
    end

    logic [SW:0] axd, ayd, azd;
    logic sxd, syd, szd;
    assign {szd, syd, sxd, azd, ayd, axd} = dly_reg[MAG_W-1];

    logic signed [TILT_W-1:0] tx, ty, tz;
    logic dgx, dgy, dgz;

    ata_lane #(.MAG_W(MAG_W), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
        .aclk(aclk), .en(en), .num_mag({axd, 8'd0}), .den_mag(hyz), .neg(sxd),
        .tilt(tx), .degen(dgx));
    ata_lane #(.MAG_W(MAG_W), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
        .aclk(aclk), .en(en), .num_mag({ayd, 8'd0}), .den_mag(hxz), .neg(syd),
        .tilt(ty), .degen(dgy));
    ata_lane #(.MAG_W(MAG_W), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
        .aclk(aclk), .en(en), .num_mag(hxy), .den_mag({azd, 8'd0}), .neg(szd),
        .tilt(tz), .degen(dgz));

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {dgz, dgy, dgx, tz, ty, tx};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
endmodule

/* rtl/core/ata_isqrt.sv */
module ata_isqrt #(
    parameter int IN_W = 50,
    parameter int OUT_W = 25
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [IN_W-1:0]  rad,
    output logic [OUT_W-1:0] root
);
    localparam int RW = 2 * OUT_W;

    logic [RW-1:0]    rem_reg   [OUT_W+1];
    logic [OUT_W-1:0] q_reg     [OUT_W+1];

    assign rem_reg[0] = RW'(rad);
    assign q_reg[0] = '0;

    genvar g;
    generate
        for (g = 0; g < OUT_W; g++) begin : g_stage
            localparam int B = OUT_W - 1 - g;
            logic [RW-1:0]    trial;
            logic [RW-1:0]    rem_next;
            logic [OUT_W-1:0] q_next;
            logic [RW-1:0]    rem_r;
            logic [OUT_W-1:0] q_r;
            always_comb begin
                trial = (RW'(q_reg[g]) << (B + 1)) + (RW'(1) << (2 * B));
                if (rem_reg[g] >= trial) begin
                    rem_next = rem_reg[g] - trial;
                    q_next = q_reg[g] | (OUT_W'(1) << B);
                end else begin
                    rem_next = rem_reg[g];
                    q_next = q_reg[g];
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_r <= rem_next;
                    q_r <= q_next;
                end
            end
            assign rem_reg[g+1] = rem_r;
            assign q_reg[g+1] = q_r;
        end
    endgenerate

    assign root = q_reg[OUT_W];
endmodule

/* rtl/core/ata_lane.sv */
module ata_lane #(
    parameter int MAG_W = 25,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [MAG_W-1:0]         num_mag,
    input  logic [MAG_W-1:0]         den_mag,
    input  logic                     neg,
    output logic signed [ata_pkg::TILT_W-1:0] tilt,
    output logic                     degen
);
    import ata_pkg::*;

    localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int VW = MAG_W + 3;
    localparam int AW = ACC_W + 2;

    logic signed [VW-1:0] xs [STEPS+1];
    logic signed [VW-1:0] ys [STEPS+1];
    logic signed [AW-1:0] as_ [STEPS+1];
    logic                 nz [STEPS+1];
    logic                 dz [STEPS+1];
    logic                 ng [STEPS+1];

    assign xs[0] = VW'(den_mag);
    assign ys[0] = VW'(num_mag);
    assign as_[0] = '0;
    assign nz[0] = (num_mag == '0);
    assign dz[0] = (den_mag == '0);
    assign ng[0] = neg;

    genvar g;
    generate
        for (g = 0; g < STEPS; g++) begin : g_step
            logic signed [VW-1:0] x_reg, y_reg;
            logic signed [AW-1:0] a_reg;
            logic nz_reg, dz_reg, ng_reg;
            logic signed [AW-1:0] t;
            assign t = AW'(atan_entry(5'(g)));
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (ys[g] > 0) begin
                        x_reg <= xs[g] + (ys[g] >>> g);
                        y_reg <= ys[g] - (xs[g] >>> g);
                        a_reg <= as_[g] + t;
                    end else begin
                        x_reg <= xs[g] - (ys[g] >>> g);
                        y_reg <= ys[g] + (xs[g] >>> g);
                        a_reg <= as_[g] - t;
                    end
                    nz_reg <= nz[g];
                    dz_reg <= dz[g];
                    ng_reg <= ng[g];
                end
            end
            assign xs[g+1] = x_reg;
            assign ys[g+1] = y_reg;
            assign as_[g+1] = a_reg;
            assign nz[g+1] = nz_reg;
            assign dz[g+1] = dz_reg;
            assign ng[g+1] = ng_reg;
        end
    endgenerate

    logic signed [AW-1:0] clamped;
    logic [AW-1:0]        rnd;
    logic [TILT_W-1:0]    mag;

    always_comb begin
        clamped = as_[STEPS];
        if (clamped < 0) clamped = '0;
        if (clamped > $signed(AW'(QUARTER_TURN))) clamped = AW'(QUARTER_TURN);
        rnd = (AW'(clamped) + (AW'(1) << (ANG_FRAC - 1))) >> ANG_FRAC;
        if (nz[STEPS]) mag = '0;
        else if (dz[STEPS]) mag = TILT_W'(9000);
        else mag = rnd[TILT_W-1:0];
        tilt = ng[STEPS] ? -$signed(mag) : $signed(mag);
        degen = dz[STEPS];
    end
endmodule

/* dv/tb_top.sv */
module tb_top;

    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int LATENCY      = SAMPLE_BITS + CORDIC_STEPS + 12;
    localparam int STALL_LIMIT  = 20000;

    typedef struct packed {
        logic [2:0]  degen;
        logic [14:0] tz;
        logic [14:0] ty;
        logic [14:0] tx;
    } tilt_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    tilt_result_t expected_tilts[$];
    int           mismatches;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           recv_hold;
    int           quiet_cycles;

    accel_tilt_angles_top #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint scaled_hypot(input longint a, input longint b);
        longint unsigned s;
        s = longint'(a * a + b * b);
        return longint'(int_sqrt(s << 16));
    endfunction

    function automatic logic [14:0] signed_angle(input longint num, input longint den,
                                                 input bit neg);
        longint px;
        longint py;
        longint acc;
        longint sx;
        longint sy;
        longint a;
        px = den;
        py = num;
        acc = 0;
        if (num == 0) return '0;
        if (den == 0) begin
            a = 9000;
        end else begin
            for (int i = 0; i < CORDIC_STEPS && i < ata_pkg::TABLE_LEN; i++) begin
                sx = py >>> i;
                sy = px >>> i;
                if (py > 0) begin
                    px = px + sx;
                    py = py - sy;
                    acc = acc + longint'(ata_pkg::atan_entry(i[4:0]));
                end else begin
                    px = px - sx;
                    py = py + sy;
                    acc = acc - longint'(ata_pkg::atan_entry(i[4:0]));
                end
            end
            if (acc < 0) acc = 0;
            if (acc > (longint'(9000) << 16)) acc = longint'(9000) << 16;
            a = (acc + 32768) >>> 16;
        end
        a = neg ? -a : a;
        return a[14:0];
    endfunction

    function automatic tilt_result_t predict_tilts(input logic signed [15:0] sx,
                                                   input logic signed [15:0] sy,
                                                   input logic signed [15:0] sz);
        tilt_result_t r;
        longint x;
        longint y;
        longint z;
        longint hyz;
        longint hxz;
        longint hxy;
        x = sx;
        y = sy;
        z = sz;
        hyz = scaled_hypot(y, z);
        hxz = scaled_hypot(x, z);
        hxy = scaled_hypot(x, y);
        r.tx = signed_angle((x < 0 ? -x : x) << 8, hyz, x < 0);
        r.ty = signed_angle((y < 0 ? -y : y) << 8, hxz, y < 0);
        r.tz = signed_angle(hxy, (z < 0 ? -z : z) << 8, z < 0);
        r.degen = {z == 0, hxz == 0, hyz == 0};
        return r;
    endfunction

    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
        expected_tilts.push_back(predict_tilts(x, y, z));
    endtask

    task automatic release_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        release_input();
        while (expected_tilts.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_count(input int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 6) - 3);
            2: return 16'(0);
            default: return 16'($urandom_range(0, 511) - 256);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] ext[5];
        ext = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
        for (int i = 0; i < 5; i++) send_sample(ext[i], ext[i], ext[i]);
        send_sample(16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h7FFF, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h7FFF, 16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h0000, 16'h7FFF);
        send_sample(16'h0001, 16'h7FFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'h0001, 16'hFFFF);
        send_sample(16'h0003, 16'h0004, 16'h0000);
        send_sample(16'h0003, 16'h0004, 16'h0005);
        send_sample(16'h8000, 16'h7FFF, 16'h8000);
        send_sample(16'h1234, 16'hEDCC, 16'h0400);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_sample(rand_count($urandom_range(0, 5) % 4),
                        rand_count($urandom_range(0, 5) % 4),
                        rand_count($urandom_range(0, 5) % 4));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge aclk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 100; i++) begin
                send_sample(rand_count(0), rand_count(0), rand_count(0));
            end
        join
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        tilt_result_t got;
        tilt_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_tilts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = expected_tilts.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp x=%0d y=%0d z=%0d m=%b act x=%0d y=%0d z=%0d m=%b",
                                 $signed(want.tx), $signed(want.ty), $signed(want.tz), want.degen,
                                 $signed(got.tx), $signed(got.ty), $signed(got.tz), got.degen);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        mismatches    = 0;
        quiet_cycles  = 0;
        recv_hold     = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 79;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(500);
        test_backpressure();
        send_idle_pct = 79;
        recv_idle_pct = 16;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(530);

        mismatches += expected_tilts.size();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
